>>> design/rtd_pkg.sv
// Shared types, constants and the character map of the radix-64 text decoder.
package rtd_pkg;

	localparam logic [7:0] COLON_CODE = 8'h3A;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       three;
	} grp_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sym_t;

	function automatic sym_t map_char(input logic [7:0] c);
		sym_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		if (c == 8'h2B) begin
			s.value = 6'd0;
		end else if (c == 8'h2D) begin
			s.value = 6'd1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd2);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41 + 8'd12);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd38);
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

endpackage

>>> design/rtd_front.sv
// Front end: classifies each character, packs sextets and writes finished groups.
module rtd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    char_code,
	input  logic          message_start,
	input  logic          q_full,
	output logic          full,
	output logic          grp_wr,
	output rtd_pkg::grp_t grp_data
);
	import rtd_pkg::*;

	logic [1:0]  pos_q, pos_d, pos_e;
	logic [17:0] buf_q, buf_d, buf_e;
	logic        halt_q, halt_d, halt_e;
	logic        accept;
	sym_t        sym;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign sym    = map_char(char_code);

	always_comb begin
		pos_e    = message_start ? 2'd0 : pos_q;
		buf_e    = message_start ? 18'd0 : buf_q;
		halt_e   = message_start ? 1'b0 : halt_q;
		pos_d    = pos_e;
		buf_d    = buf_e;
		halt_d   = halt_e;
		grp_wr   = 1'b0;
		grp_data = '{b0: buf_e[17:10], b1: buf_e[9:2], b2: {buf_e[1:0], sym.value},
			three: 1'b1};
		if (message_start && char_code == COLON_CODE) begin
			// skip leading colon
		end else if (halt_e) begin
			// drop
		end else if (!sym.valid) begin
			if (char_code == COLON_CODE && pos_e == 2'd3) begin
				grp_wr         = 1'b1;
				grp_data.three = 1'b0;
			end
			halt_d = 1'b1;
			pos_d  = 2'd0;
			buf_d  = 18'd0;
		end else if (pos_e != 2'd3) begin
			buf_d = {buf_e[11:0], sym.value};
			pos_d = pos_e + 2'd1;
		end else begin
			grp_wr = 1'b1;
			pos_d  = 2'd0;
			buf_d  = 18'd0;
		end
		grp_wr = grp_wr && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			buf_q  <= 18'd0;
			halt_q <= 1'b0;
		end else if (accept) begin
			pos_q  <= pos_d;
			buf_q  <= buf_d;
			halt_q <= halt_d;
		end
	end

	a_halt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> (pos_q == 2'd0 && buf_q == 18'd0))
		else $error("halted decoder holds sextets");

	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		grp_wr |-> !q_full)
		else $error("group written into full queue");

endmodule

>>> design/rtd_fifo.sv
// Short group queue between the front end and the byte serializer.
module rtd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rtd_pkg::grp_t wr_data,
	input  logic          rd,
	output rtd_pkg::grp_t rd_data,
	output logic          full,
	output logic          nonempty
);
	import rtd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("group queue overflow");

endmodule

>>> design/rtd_back.sv
// Back end: holds one group and hands its bytes out one word at a time.
module rtd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  rtd_pkg::grp_t q_data,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    decoded_byte,
	output logic          last_of_run
);
	import rtd_pkg::*;

	grp_t       hold_q;
	logic       vld_q;
	logic [1:0] idx_q;
	logic       take;

	assign empty       = !vld_q;
	assign take        = pop && vld_q;
	assign last_of_run = hold_q.three ? (idx_q == 2'd2) : (idx_q == 2'd1);
	assign q_rd        = q_nonempty && (!vld_q || (take && last_of_run));

	always_comb begin
		case (idx_q)
			2'd0:    decoded_byte = hold_q.b0;
			2'd1:    decoded_byte = hold_q.b1;
			default: decoded_byte = hold_q.b2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			hold_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (q_rd) begin
			vld_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (take) begin
			if (last_of_run) begin
				vld_q <= 1'b0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (idx_q != 2'd3 && (hold_q.three || idx_q != 2'd2)))
		else $error("byte index past end of group");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q |-> idx_q == 2'd0)
		else $error("idle serializer holds stale index");

endmodule

>>> design/radix64_text_decoder_unit.sv
// Radix-64 text decoder top level: front end, group queue and byte serializer.
// A finished group is written to the queue at the edge that accepts its final
// character. The front end takes one character per cycle while the queue is
// not full; the serializer loads each group and hands out its bytes in turn on
// the single result port. Reset clears decoder state, queue and serializer.
module radix64_text_decoder_unit #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       message_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] decoded_byte,
	output logic       last_of_run
);
	import rtd_pkg::*;

	logic q_full, q_nonempty, grp_wr, q_rd;
	grp_t grp_data, q_data;

	rtd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.char_code     (char_code),
		.message_start (message_start),
		.q_full        (q_full),
		.full          (full),
		.grp_wr        (grp_wr),
		.grp_data      (grp_data)
	);

	rtd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (grp_wr),
		.wr_data  (grp_data),
		.rd       (q_rd),
		.rd_data  (q_data),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	rtd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_data),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.decoded_byte (decoded_byte),
		.last_of_run  (last_of_run)
	);

endmodule

>>> verif/rtd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the radix-64 text decoder: predicts the decoded bytes and checks each one.
module rtd_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] char_code,
	input  logic       message_start,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] decoded_byte,
	input  logic       last_of_run,
	output int         errors,
	output int         pending
);
	import rtd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dec_word_t;

	dec_word_t   expected_bytes[$];
	logic [1:0]  grp_pos;
	logic [17:0] sextets;
	logic        stopped;

	// {valid, value}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		if (c == 8'h2B) return {1'b1, 6'd0};
		if (c == 8'h2D) return {1'b1, 6'd1};
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h2E)};
		if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h35)};
		if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h3B)};
		return 7'd0;
	endfunction

	task automatic expect_byte(input logic [7:0] data, input logic last);
		dec_word_t w;
		w.data = data;
		w.last = last;
		expected_bytes.push_back(w);
	endtask

	task automatic decode_char(input logic [7:0] c, input logic s);
		logic [6:0]  sx;
		logic [23:0] grp;
		sx = sextet_of(c);
		if (s) begin
			grp_pos = 2'd0;
			sextets = '0;
			stopped = 1'b0;
			if (c == COLON_CODE) return;
		end
		if (stopped) return;
		if (!sx[6]) begin
			if (c == COLON_CODE && grp_pos == 2'd3) begin
				expect_byte(sextets[17:10], 1'b0);
				expect_byte(sextets[9:2], 1'b1);
			end
			stopped = 1'b1;
			grp_pos = 2'd0;
			sextets = '0;
		end else if (grp_pos != 2'd3) begin
			sextets = {sextets[11:0], sx[5:0]};
			grp_pos = grp_pos + 2'd1;
		end else begin
			grp = {sextets, sx[5:0]};
			expect_byte(grp[23:16], 1'b0);
			expect_byte(grp[15:8], 1'b0);
			expect_byte(grp[7:0], 1'b1);
			grp_pos = 2'd0;
			sextets = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		dec_word_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			grp_pos = 2'd0;
			sextets = '0;
			stopped = 1'b0;
			errors = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected word data=%02h last=%0b", $realtime,
							decoded_byte, last_of_run);
				end else begin
					want = expected_bytes.pop_front();
					if (want.data !== decoded_byte || want.last !== last_of_run) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch data exp=%02h got=%02h last exp=%0b got=%0b",
								$realtime, want.data, decoded_byte, want.last, last_of_run);
					end
				end
			end
			if (push && !full)
				decode_char(char_code, message_start);
			pending = expected_bytes.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench of the radix-64 text decoder: clock, reset, stimulus and verdict.
module tb_top;
	import rtd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_code;
	logic       message_start;
	logic       empty;
	logic       pop;
	logic [7:0] decoded_byte;
	logic       last_of_run;
	logic       hold_pop;
	int         errors;
	int         pending;
	int         send_idle;
	int         recv_idle;
	int         sent;
	int         stall_cycles = 0;

	radix64_text_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.message_start(message_start),
		.empty        (empty),
		.pop          (pop),
		.decoded_byte (decoded_byte),
		.last_of_run  (last_of_run)
	);

	rtd_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.message_start(message_start),
		.empty        (empty),
		.pop          (pop),
		.decoded_byte (decoded_byte),
		.last_of_run  (last_of_run),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		pop <= !hold_pop && ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL radix64_text_decoder_unit");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [7:0] valid_char(input int v);
		if (v == 0) return 8'h2B;
		if (v == 1) return 8'h2D;
		if (v < 12) return 8'(8'h2E + v);
		if (v < 38) return 8'(8'h35 + v);
		return 8'(8'h3B + v);
	endfunction

	function automatic logic [7:0] invalid_char();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(8'h00, 8'h2A));
			1: return 8'h2C;
			2: return 8'($urandom_range(8'h2E, 8'h2F));
			3: return 8'($urandom_range(8'h3A, 8'h40));
			4: return 8'($urandom_range(8'h5B, 8'h60));
			default: return 8'($urandom_range(8'h7B, 8'hFF));
		endcase
	endfunction

	task automatic send_item(input logic [7:0] c, input logic s);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		message_start <= s;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic send_message();
		int   kind;
		logic first;
		kind = $urandom_range(0, 9);
		first = 1'b1;
		if (kind >= 8) begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
			repeat ($urandom_range(0, 7))
				send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			return;
		end
		if ($urandom_range(0, 1)) begin
			send_item(COLON_CODE, 1'b1);
			first = 1'b0;
		end
		repeat (4 * $urandom_range(0, 3)) begin
			send_item(valid_char($urandom_range(0, 63)), first);
			first = 1'b0;
		end
		case ($urandom_range(0, 4))
			1: begin
				repeat (3) begin
					send_item(valid_char($urandom_range(0, 63)), first);
					first = 1'b0;
				end
				send_item(COLON_CODE, 1'b0);
			end
			2: begin
				repeat ($urandom_range(1, 3)) begin
					send_item(valid_char($urandom_range(0, 63)), first);
					first = 1'b0;
				end
			end
			3: begin
				send_item(invalid_char(), first);
				repeat ($urandom_range(0, 2))
					send_item(8'($urandom_range(0, 255)), 1'b0);
			end
			4: begin
				repeat ($urandom_range(0, 2)) begin
					send_item(valid_char($urandom_range(0, 63)), first);
					first = 1'b0;
				end
				send_item(COLON_CODE, first);
			end
			default: ;
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		char_code = 8'h00;
		message_start = 1'b0;
		hold_pop = 1'b0;
		send_idle = 14;
		recv_idle = 73;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(COLON_CODE, 1'b0);
		send_item(COLON_CODE, 1'b1);
		send_item("+", 1'b0);
		send_item("-", 1'b0);
		send_item("0", 1'b0);
		send_item("9", 1'b0);
		send_item("A", 1'b0);
		send_item("Z", 1'b0);
		send_item("a", 1'b0);
		send_item("z", 1'b0);
		send_item("z", 1'b1);
		send_item("z", 1'b0);
		send_item("z", 1'b0);
		send_item(COLON_CODE, 1'b0);
		send_item("+", 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item("x", 1'b1);
		send_item("y", 1'b0);
		send_item("c", 1'b1);
		send_item("d", 1'b0);
		send_item("e", 1'b0);
		send_item("f", 1'b0);
		send_item(COLON_CODE, 1'b0);

		while (sent < 80) send_message();
		send_idle = 73;
		recv_idle = 14;
		while (sent < 140) send_message();
		send_idle = 0;
		recv_idle = 0;

		fork
			begin
				hold_pop <= 1'b1;
				repeat (80) @(posedge clk);
				hold_pop <= 1'b0;
			end
		join_none
		send_item(valid_char($urandom_range(0, 63)), 1'b1);
		repeat (31) send_item(valid_char($urandom_range(0, 63)), 1'b0);

		while (sent < 200) send_message();
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS radix64_text_decoder_unit");
		end else begin
			$display("FAIL radix64_text_decoder_unit");
		end
		$finish;
	end

endmodule
